// ----- hw/rtl/pidaw_pkg.sv -----
// Shared types, constants and the microcode program of the PID controller.
// Used by pidaw_sequencer, pidaw_datapath and pid_controller_antiwindup.
package pidaw_pkg;

    // Datapath widths.
    localparam int GAIN_W     = 16;
    localparam int SAMPLE_W   = 16;
    localparam int TRIM_W     = 12;
    localparam int LIMIT_W    = 31;
    localparam int DRIVE_W    = 32;
    localparam int ERR_W      = SAMPLE_W + 1;
    localparam int INT_W      = 48;
    localparam int ACC_W      = 50;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 64;
    localparam int P_RAW_W    = 45;
    localparam int MAG_W      = 31;
    localparam int FRAC_W     = 8;
    localparam int TRIM_FRAC  = 11;

    // Truncating divide by ten: q = (n * RECIP_TEN) >> RECIP_SHIFT, exact for n < 2^31.
    localparam int RECIP_SHIFT = 34;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam logic signed [MUL_W-1:0] RECIP_TEN = 33'sh066666667;

    // Saturation bounds in accumulator width.
    localparam logic signed [ACC_W-1:0] INT_MAX =
        {{(ACC_W-INT_W+1){1'b0}}, {(INT_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] INT_MIN = ~INT_MAX;
    localparam logic signed [ACC_W-1:0] DRIVE_MAX =
        {{(ACC_W-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] DRIVE_MIN = ~DRIVE_MAX;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 2;
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_GAIN_P,
        REG_GAIN_I,
        REG_GAIN_D,
        REG_WINDUP
    } cfg_index_t;

    // Sequencer step numbers.
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;
    localparam step_t STEP_IDLE   = 4'd0;
    localparam step_t STEP_MUL_I  = 4'd1;
    localparam step_t STEP_SCALE  = 4'd2;
    localparam step_t STEP_SAT    = 4'd3;
    localparam step_t STEP_CLAMP  = 4'd4;
    localparam step_t STEP_ADD_P  = 4'd5;
    localparam step_t STEP_ABS_D  = 4'd6;
    localparam step_t STEP_RECIP  = 4'd7;
    localparam step_t STEP_ADD_D  = 4'd8;
    localparam step_t STEP_OUT    = 4'd9;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_INT,
        MUL_PROP,
        MUL_TRIM,
        MUL_DERIV,
        MUL_RECIP
    } mul_sel_t;

    typedef enum logic [3:0] {
        ALU_NONE,
        ALU_INT_SCALE,
        ALU_SAT_INT,
        ALU_CLAMP,
        ALU_ADD_P,
        ALU_ABS_D,
        ALU_ADD_D,
        ALU_OUT
    } alu_sel_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_HOLD_IN,
        JMP_SKIP_NOLIM,
        JMP_HOLD_OUT
    } jmp_cond_t;

    typedef struct packed {
        logic      take_in;
        mul_sel_t  mul;
        alu_sel_t  alu;
        logic      store_int;
        jmp_cond_t jmp;
        step_t     target;
    } ctrl_t;

    typedef struct packed {
        logic in_accept;
        logic limit_zero;
        logic out_free;
    } stat_t;

    // The control program. A multiplier result lands in the product register at the
    // end of its step, so the step after it is the first that can use it.
    function automatic ctrl_t ucode(input step_t step);
        ctrl_t w;
        w = '{take_in: 1'b0, mul: MUL_NONE, alu: ALU_NONE, store_int: 1'b0,
              jmp: JMP_NEXT, target: STEP_IDLE};
        case (step)
            STEP_IDLE:
            begin
                w.take_in = 1'b1;
                w.jmp     = JMP_HOLD_IN;
                w.target  = STEP_MUL_I;
            end
            STEP_MUL_I:
            begin
                w.mul = MUL_INT;
            end
            STEP_SCALE:
            begin
                w.mul = MUL_PROP;
                w.alu = ALU_INT_SCALE;
            end
            STEP_SAT:
            begin
                w.mul    = MUL_TRIM;
                w.alu    = ALU_SAT_INT;
                w.jmp    = JMP_SKIP_NOLIM;
                w.target = STEP_ADD_P;
            end
            STEP_CLAMP:
            begin
                w.alu = ALU_CLAMP;
            end
            STEP_ADD_P:
            begin
                w.mul       = MUL_DERIV;
                w.alu       = ALU_ADD_P;
                w.store_int = 1'b1;
            end
            STEP_ABS_D:
            begin
                w.alu = ALU_ABS_D;
            end
            STEP_RECIP:
            begin
                w.mul = MUL_RECIP;
            end
            STEP_ADD_D:
            begin
                w.alu = ALU_ADD_D;
            end
            STEP_OUT:
            begin
                w.alu    = ALU_OUT;
                w.jmp    = JMP_HOLD_OUT;
                w.target = STEP_IDLE;
            end
            default:
            begin
                w.jmp    = JMP_HOLD_OUT;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- hw/rtl/pidaw_sequencer.sv -----
// Step counter and microcode lookup of the PID controller.
// Depends on pidaw_pkg for the control word, status flags and program.
module pidaw_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  pidaw_pkg::stat_t  stat,
    output pidaw_pkg::ctrl_t  ctrl
);

    pidaw_pkg::step_t step_reg;
    pidaw_pkg::step_t step_next;

    assign ctrl = pidaw_pkg::ucode(step_reg);

    always_comb
    begin
        step_next = step_reg + pidaw_pkg::step_t'(1);
        case (ctrl.jmp)
            pidaw_pkg::JMP_NEXT:
            begin
                step_next = step_reg + pidaw_pkg::step_t'(1);
            end
            pidaw_pkg::JMP_HOLD_IN:
            begin
                step_next = stat.in_accept ? ctrl.target : step_reg;
            end
            pidaw_pkg::JMP_SKIP_NOLIM:
            begin
                step_next = stat.limit_zero ? ctrl.target
                                            : step_reg + pidaw_pkg::step_t'(1);
            end
            pidaw_pkg::JMP_HOLD_OUT:
            begin
                step_next = stat.out_free ? ctrl.target : step_reg;
            end
            default:
            begin
                step_next = pidaw_pkg::STEP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= pidaw_pkg::STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ----- hw/rtl/pidaw_datapath.sv -----
// Datapath of the PID controller: configuration registers, shared multiplier,
// accumulator ALU, controller state and the output register. Depends on pidaw_pkg.
module pidaw_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pidaw_pkg::ctrl_t                      ctrl,
    output pidaw_pkg::stat_t                      stat,
    input  logic                                  cfg_we,
    input  logic [pidaw_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [pidaw_pkg::LIMIT_W-1:0]         cfg_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [47:0]                           s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [31:0]                           m_tdata
);

    localparam int ACC_W = pidaw_pkg::ACC_W;
    localparam int MUL_W = pidaw_pkg::MUL_W;

    // Configuration and controller state.
    logic signed [pidaw_pkg::GAIN_W-1:0]   gain_p_reg;
    logic signed [pidaw_pkg::GAIN_W-1:0]   gain_i_reg;
    logic signed [pidaw_pkg::GAIN_W-1:0]   gain_d_reg;
    logic        [pidaw_pkg::LIMIT_W-1:0]  windup_reg;
    logic signed [pidaw_pkg::INT_W-1:0]    integral_reg;
    logic signed [pidaw_pkg::SAMPLE_W-1:0] last_meas_reg;
    logic                                  out_valid_reg;

    // Working registers of one transaction.
    logic signed [pidaw_pkg::ERR_W-1:0]    err_reg;
    logic signed [pidaw_pkg::ERR_W-1:0]    dm_reg;
    logic        [pidaw_pkg::TRIM_W-1:0]   trim_reg;
    logic signed [pidaw_pkg::PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]               acc_reg;
    logic signed [ACC_W-1:0]               acc_next;
    logic        [pidaw_pkg::MAG_W-1:0]    mag_reg;
    logic        [pidaw_pkg::MAG_W-1:0]    mag_next;
    logic                                  neg_reg;
    logic        [pidaw_pkg::DRIVE_W-1:0]  drive_reg;
    logic        [pidaw_pkg::DRIVE_W-1:0]  drive_next;

    logic signed [pidaw_pkg::SAMPLE_W-1:0] in_setpoint;
    logic signed [pidaw_pkg::SAMPLE_W-1:0] in_meas;
    logic        [pidaw_pkg::TRIM_W-1:0]   in_trim;
    logic                                  in_accept;
    logic                                  out_load;

    logic signed [MUL_W-1:0]               mul_a;
    logic signed [MUL_W-1:0]               mul_b;
    logic signed [2*MUL_W-1:0]             mul_full;

    logic signed [MUL_W-1:0]               prod_lo;
    logic signed [ACC_W-1:0]               prod_ext;
    logic signed [ACC_W-1:0]               int_ext;
    logic signed [pidaw_pkg::P_RAW_W-1:0]  p_raw;
    logic signed [pidaw_pkg::P_RAW_W-1:0]  p_term;
    logic signed [ACC_W-1:0]               lim_pos;
    logic signed [ACC_W-1:0]               lim_neg;
    logic signed [MUL_W-1:0]               d_abs;
    logic        [pidaw_pkg::QUOT_W-1:0]   quot;
    logic signed [ACC_W-1:0]               quot_ext;
    logic signed [ACC_W-1:0]               drive_wide;

    assign in_setpoint = s_tdata[15:0];
    assign in_meas     = s_tdata[31:16];
    assign in_trim     = s_tdata[43:32];

    assign s_tready  = ctrl.take_in;
    assign in_accept = s_tvalid && ctrl.take_in;
    assign out_load  = (ctrl.alu == pidaw_pkg::ALU_OUT) && stat.out_free;

    assign stat.in_accept  = in_accept;
    assign stat.limit_zero = (windup_reg == '0);
    assign stat.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = drive_reg;

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.mul)
            pidaw_pkg::MUL_INT:
            begin
                mul_a = MUL_W'(gain_i_reg);
                mul_b = MUL_W'(err_reg);
            end
            pidaw_pkg::MUL_PROP:
            begin
                mul_a = MUL_W'(err_reg);
                mul_b = MUL_W'(gain_p_reg);
            end
            pidaw_pkg::MUL_TRIM:
            begin
                mul_a = prod_lo;
                mul_b = MUL_W'(trim_reg);
            end
            pidaw_pkg::MUL_DERIV:
            begin
                mul_a = MUL_W'(gain_d_reg);
                mul_b = MUL_W'(dm_reg);
            end
            pidaw_pkg::MUL_RECIP:
            begin
                mul_a = MUL_W'(mag_reg);
                mul_b = pidaw_pkg::RECIP_TEN;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // Operand views of the product register.
    assign prod_lo  = prod_reg[MUL_W-1:0];
    assign prod_ext = ACC_W'(prod_lo);
    assign int_ext  = ACC_W'(integral_reg);
    assign p_raw    = prod_reg[pidaw_pkg::P_RAW_W-1:0];
    assign p_term   = p_raw >>> pidaw_pkg::TRIM_FRAC;
    assign lim_pos  = ACC_W'({windup_reg, {pidaw_pkg::FRAC_W{1'b0}}});
    assign lim_neg  = -lim_pos;
    assign d_abs    = prod_lo[MUL_W-1] ? -prod_lo : prod_lo;
    assign quot     = prod_reg[pidaw_pkg::PROD_W-1:pidaw_pkg::RECIP_SHIFT];
    assign quot_ext = ACC_W'(quot);
    assign drive_wide = acc_reg >>> pidaw_pkg::FRAC_W;
    assign mag_next   = d_abs[pidaw_pkg::MAG_W-1:0];

    always_comb
    begin
        acc_next = acc_reg;
        case (ctrl.alu)
            pidaw_pkg::ALU_INT_SCALE:
            begin
                // integral + 10 * (gain_i * error)
                acc_next = int_ext + (prod_ext <<< 3) + (prod_ext <<< 1);
            end
            pidaw_pkg::ALU_SAT_INT:
            begin
                if (acc_reg > pidaw_pkg::INT_MAX)
                begin
                    acc_next = pidaw_pkg::INT_MAX;
                end
                else if (acc_reg < pidaw_pkg::INT_MIN)
                begin
                    acc_next = pidaw_pkg::INT_MIN;
                end
            end
            pidaw_pkg::ALU_CLAMP:
            begin
                if (acc_reg >= lim_pos)
                begin
                    acc_next = lim_pos;
                end
                else if (acc_reg <= lim_neg)
                begin
                    acc_next = lim_neg;
                end
            end
            pidaw_pkg::ALU_ADD_P:
            begin
                acc_next = acc_reg + ACC_W'(p_term);
            end
            pidaw_pkg::ALU_ADD_D:
            begin
                // The quotient is of the magnitude, so the sign is applied here.
                acc_next = neg_reg ? acc_reg - quot_ext : acc_reg + quot_ext;
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_comb
    begin
        if (drive_wide > pidaw_pkg::DRIVE_MAX)
        begin
            drive_next = pidaw_pkg::DRIVE_MAX[pidaw_pkg::DRIVE_W-1:0];
        end
        else if (drive_wide < pidaw_pkg::DRIVE_MIN)
        begin
            drive_next = pidaw_pkg::DRIVE_MIN[pidaw_pkg::DRIVE_W-1:0];
        end
        else
        begin
            drive_next = drive_wide[pidaw_pkg::DRIVE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            windup_reg    <= '0;
            integral_reg  <= '0;
            last_meas_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (pidaw_pkg::cfg_index_t'(cfg_addr))
                    pidaw_pkg::REG_GAIN_P: gain_p_reg <= cfg_data[pidaw_pkg::GAIN_W-1:0];
                    pidaw_pkg::REG_GAIN_I: gain_i_reg <= cfg_data[pidaw_pkg::GAIN_W-1:0];
                    pidaw_pkg::REG_GAIN_D: gain_d_reg <= cfg_data[pidaw_pkg::GAIN_W-1:0];
                    pidaw_pkg::REG_WINDUP: windup_reg <= cfg_data;
                    default:
                    begin
                        windup_reg <= windup_reg;
                    end
                endcase
            end
            if (in_accept)
            begin
                last_meas_reg <= in_meas;
            end
            if (ctrl.store_int)
            begin
                integral_reg <= acc_reg[pidaw_pkg::INT_W-1:0];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            err_reg  <= pidaw_pkg::ERR_W'(in_setpoint) - pidaw_pkg::ERR_W'(in_meas);
            dm_reg   <= pidaw_pkg::ERR_W'(last_meas_reg) - pidaw_pkg::ERR_W'(in_meas);
            trim_reg <= in_trim;
        end
        if (ctrl.mul != pidaw_pkg::MUL_NONE)
        begin
            prod_reg <= mul_full[pidaw_pkg::PROD_W-1:0];
        end
        if (ctrl.alu == pidaw_pkg::ALU_ABS_D)
        begin
            neg_reg <= prod_lo[MUL_W-1];
            mag_reg <= mag_next;
        end
        acc_reg <= acc_next;
        if (out_load)
        begin
            drive_reg <= drive_next;
        end
    end

endmodule

// ----- hw/rtl/pid_controller_antiwindup.sv -----
// Top level of the PID controller with integral clamp.
// Instantiates pidaw_sequencer and pidaw_datapath; depends on pidaw_pkg.
//
// One input transaction (setpoint, measurement, trim) gives one drive
// transaction. The block takes a transaction in its idle step and is ready for
// the next one when the microcode program has stepped back to idle, which
// skips the clamp step when windup_limit is zero; a stalled output holds it in
// the output step. The program runs the five products of a tick
// (integral, two for the P term, D term, divide by ten) one after the other
// through a single 33x33 multiplier and a single accumulator ALU. A finished
// drive value sits in an output register, so the next transaction is taken
// while it waits. Configuration writes take effect at once and are meant for
// an idle block. No clearing pass follows reset.
module pid_controller_antiwindup (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [30:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // setpoint[15:0], measurement[31:16], p_trim[43:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // drive[31:0]
);

    pidaw_pkg::ctrl_t ctrl;
    pidaw_pkg::stat_t stat;

    pidaw_sequencer u_sequencer (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    pidaw_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .stat     (stat),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
